### rtl/core/dtti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_pkg
// Shared types, codes and helpers of the decimal text to integer converter.
// ----------------------------------------------------------------------------
package dtti_pkg;

  // Widest result the converter produces
  localparam int unsigned MAX_BITS = 64;
  localparam int unsigned PROD_W   = MAX_BITS + 4;

  // ASCII codes of the grammar
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;

  // Configuration register indexes
  localparam logic CFG_WIDTH_MODE  = 1'b0;
  localparam logic CFG_SIGNED_MODE = 1'b1;

  // Width mode codes
  localparam logic [1:0] WM_8  = 2'd0;
  localparam logic [1:0] WM_16 = 2'd1;
  localparam logic [1:0] WM_32 = 2'd2;
  localparam logic [1:0] WM_64 = 2'd3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_ENDED  = 4'b1000
  } phase_e;

  // Per-string parse state
  typedef struct packed {
    logic [MAX_BITS-1:0] acc;
    logic                neg;
    phase_e              phase;
    status_e             fail;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    acc:   '0,
    neg:   1'b0,
    phase: PH_START,
    fail:  ST_OK
  };

  // All-ones mask of w bits, capped at MAX_BITS
  function automatic logic [MAX_BITS-1:0] ones_mask(input int unsigned w);
    logic [MAX_BITS-1:0] m;
    if (w >= MAX_BITS) begin
      m = '1;
    end else begin
      m = (MAX_BITS'(1) << w) - MAX_BITS'(1);
    end
    return m;
  endfunction

  // Largest magnitude allowed for the configured width and sign
  function automatic logic [MAX_BITS-1:0] magnitude_limit(input logic [1:0] width_mode,
                                                          input logic       signed_mode,
                                                          input logic       neg);
    logic [MAX_BITS-1:0] mask;
    logic [MAX_BITS-1:0] half_m1;
    case (width_mode)
      WM_8:    mask = ones_mask(8);
      WM_16:   mask = ones_mask(16);
      WM_32:   mask = ones_mask(32);
      WM_64:   mask = ones_mask(64);
      default: mask = ones_mask(MAX_BITS);
    endcase
    half_m1 = mask >> 1;
    if (!signed_mode) begin
      return mask;
    end else if (neg) begin
      return half_m1 + MAX_BITS'(1);
    end else begin
      return half_m1;
    end
  endfunction

endpackage

### rtl/core/dtti_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_step
// One parse step: folds a text byte into the parse state and, on the last
// byte, forms the result value and status and clears the state.
// ----------------------------------------------------------------------------
module dtti_step (
  input  dtti_pkg::parse_state_t         state_i,
  input  logic [7:0]                     char_byte_i,
  input  logic                           last_byte_i,
  input  logic [1:0]                     width_mode_i,
  input  logic                           signed_mode_i,
  output dtti_pkg::parse_state_t         state_o,
  output logic [dtti_pkg::MAX_BITS-1:0]  value_o,
  output dtti_pkg::status_e              status_o
);

  logic                          char_is_num;
  logic [7:0]                    digit_full;
  logic [3:0]                    digit_val;
  logic [dtti_pkg::PROD_W-1:0]   acc_ext;
  logic [dtti_pkg::PROD_W-1:0]   prod;
  logic [dtti_pkg::MAX_BITS-1:0] limit;
  dtti_pkg::parse_state_t        upd;

  // Decode the byte
  assign char_is_num = (char_byte_i >= dtti_pkg::CHAR_ZERO) &&
                       (char_byte_i <= dtti_pkg::CHAR_NINE);
  assign digit_full  = char_byte_i - dtti_pkg::CHAR_ZERO;
  assign digit_val   = digit_full[3:0];

  // acc*10 + digit as shift-add, wide enough never to wrap
  assign acc_ext = {4'b0, state_i.acc};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) +
                   {{(dtti_pkg::PROD_W-4){1'b0}}, digit_val};
  assign limit   = dtti_pkg::magnitude_limit(width_mode_i, signed_mode_i, state_i.neg);

  // Advance the grammar
  always_comb begin
    upd = state_i;
    if (state_i.fail != dtti_pkg::ST_OK || state_i.phase == dtti_pkg::PH_ENDED) begin
      upd = state_i;
    end else if (char_is_num) begin
      if (prod > {4'b0, limit}) begin
        upd.fail = dtti_pkg::ST_RANGE;
      end else begin
        upd.acc   = prod[dtti_pkg::MAX_BITS-1:0];
        upd.phase = dtti_pkg::PH_DIGITS;
      end
    end else if (state_i.phase == dtti_pkg::PH_START &&
                 char_byte_i == dtti_pkg::CHAR_MINUS) begin
      if (signed_mode_i) begin
        upd.neg   = 1'b1;
        upd.phase = dtti_pkg::PH_SIGN;
      end else begin
        upd.fail = dtti_pkg::ST_SYNTAX;
      end
    end else if (state_i.phase == dtti_pkg::PH_START &&
                 char_byte_i == dtti_pkg::CHAR_PLUS) begin
      upd.phase = dtti_pkg::PH_SIGN;
    end else if (state_i.phase == dtti_pkg::PH_DIGITS) begin
      upd.phase = dtti_pkg::PH_ENDED;
    end else begin
      upd.fail = dtti_pkg::ST_SYNTAX;
    end
  end

  // Form the result and clear the state at the end of a string
  always_comb begin
    state_o  = upd;
    value_o  = '0;
    status_o = upd.fail;
    if (last_byte_i) begin
      if (status_o == dtti_pkg::ST_OK && upd.phase != dtti_pkg::PH_DIGITS &&
          upd.phase != dtti_pkg::PH_ENDED) begin
        status_o = dtti_pkg::ST_SYNTAX;
      end
      if (status_o == dtti_pkg::ST_OK) begin
        value_o = upd.neg ? ('0 - upd.acc) : upd.acc;
      end
      state_o = dtti_pkg::STATE_CLEAR;
    end
  end

endmodule

### rtl/core/decimal_text_to_integer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// Converts the ASCII text of a decimal number, one byte per request, to a
// 64-bit integer with a syntax and range status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one text byte per request;
//   last_byte_i marks the final byte of a string. Output channel
//   (out_valid_o/out_ready_i) carries one result per string: value_bits_o
//   (sign-extended two's complement, zero on failure) and status_o
//   (0 ok, 1 bad syntax, 2 out of range).
//   Throughput: one byte per cycle while no last byte is held back. A byte
//   waits in the input register and is folded into the parse state on its
//   way out; a last byte loads its result into the output register at that
//   same edge, so out_valid_o rises as that byte leaves the input register.
//   When the receiver stalls, the held result blocks only the next last
//   byte; non-final bytes keep flowing through the input register.
//   Configuration: cfg_we_i writes width_mode (index 0) or signed_mode
//   (index 1) from cfg_data_i; write only while no string is in flight.
//   Reset: width_mode 64 bits, signed mode, parse state cleared, both
//   channels empty.
// ----------------------------------------------------------------------------
module decimal_text_to_integer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  // text bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        last_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_bits_o,
  output logic [1:0]  status_o
);

  logic [1:0]                    width_mode_q;
  logic                          signed_mode_q;
  logic                          s1_valid_q;
  logic [7:0]                    s1_byte_q;
  logic                          s1_last_q;
  logic                          s1_fire;
  dtti_pkg::parse_state_t        state_q;
  dtti_pkg::parse_state_t        state_d;
  logic [dtti_pkg::MAX_BITS-1:0] res_value;
  dtti_pkg::status_e             res_status;
  logic                          out_valid_q;
  logic [dtti_pkg::MAX_BITS-1:0] out_value_q;
  dtti_pkg::status_e             out_status_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mode_q  <= dtti_pkg::WM_64;
      signed_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dtti_pkg::CFG_WIDTH_MODE:  width_mode_q  <= cfg_data_i;
        dtti_pkg::CFG_SIGNED_MODE: signed_mode_q <= cfg_data_i[0];
        default:                   width_mode_q  <= width_mode_q;
      endcase
    end
  end

  // Advance a byte when it has no result or the output slot frees up
  assign s1_fire    = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // Hold the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= char_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  dtti_step u_step (
    .state_i       (state_q),
    .char_byte_i   (s1_byte_q),
    .last_byte_i   (s1_last_q),
    .width_mode_i  (width_mode_q),
    .signed_mode_i (signed_mode_q),
    .state_o       (state_d),
    .value_o       (res_value),
    .status_o      (res_status)
  );

  // Update the parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtti_pkg::STATE_CLEAR;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  // Load or drop the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_value_q  <= res_value;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_bits_o = out_value_q;
  assign status_o     = out_status_q;

`ifndef NO_ASSERTIONS
  // A new result comes only from a last byte leaving the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("result appeared without a last byte");

  // A failed conversion carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != dtti_pkg::ST_OK) |-> (out_value_q == '0))
    else $error("failed result with nonzero value");

  // The parse state is clear after a string ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (state_q == dtti_pkg::STATE_CLEAR))
    else $error("parse state not cleared at end of string");

  // Input backpressure only while a byte is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_last_q && out_valid_q))
    else $error("input stalled without a blocked result");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the decimal text to integer converter. A short
// table of directed strings covers the 8- and 16-bit width and sign limits, lone signs,
// bad leading bytes and trailing text. Random number text then runs under
// every width and sign setting. Both channels idle at random, and every
// result is checked field by field against a typed expectation or a conversion model kept here.
// ----------------------------------------------------------------------------
module testbench;
  import dtti_pkg::*;

  typedef logic [7:0] text_q_t[$];

  typedef struct {
    logic [63:0] value;
    status_e     status;
  } conv_result_t;

  typedef struct {
    logic [1:0]  width_mode;
    logic        signed_mode;
    string       text;
    bit          typed;
    logic [63:0] value;
    status_e     status;
  } text_case_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [1:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] value_bits;
  logic [1:0]  status;

  // Conversion model: configuration and per-string parse state
  logic [1:0]  model_width;
  logic        model_signed;
  logic [63:0] model_acc;
  logic        model_neg;
  phase_e      model_phase;
  status_e     model_fail;

  conv_result_t pending_conversions[$];
  int unsigned  mismatch_count;
  int unsigned  live_bytes;
  bit           calm;

  decimal_text_to_integer DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .char_byte_i  (char_byte),
    .last_byte_i  (last_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .value_bits_o (value_bits),
    .status_o     (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Largest magnitude that a string may reach
  function automatic logic [63:0] range_limit(input logic [1:0] wm, input logic sm,
                                              input logic ng);
    int unsigned w;
    logic [63:0] half;
    w    = 8 << wm;
    half = 64'd1 << (w - 1);
    if (!sm) begin
      return half - 64'd1 + half;
    end
    return ng ? half : half - 64'd1;
  endfunction

  // Fold one text byte into the model; report a result on the last byte
  task automatic fold_text_byte(input logic [7:0] c, input logic lst,
                                output bit produced, output conv_result_t res);
    logic [63:0] d;
    logic [63:0] lim;
    status_e     st;
    produced = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    if (model_fail == ST_OK && model_phase != PH_ENDED) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        d   = 64'(c - CHAR_ZERO);
        lim = range_limit(model_width, model_signed, model_neg);
        if (model_acc > (lim - d) / 64'd10) begin
          model_fail = ST_RANGE;
        end else begin
          model_acc   = model_acc * 64'd10 + d;
          model_phase = PH_DIGITS;
        end
      end else if (model_phase == PH_START && c == CHAR_MINUS) begin
        if (model_signed) begin
          model_neg   = 1'b1;
          model_phase = PH_SIGN;
        end else begin
          model_fail = ST_SYNTAX;
        end
      end else if (model_phase == PH_START && c == CHAR_PLUS) begin
        model_phase = PH_SIGN;
      end else if (model_phase == PH_DIGITS) begin
        model_phase = PH_ENDED;
      end else begin
        model_fail = ST_SYNTAX;
      end
    end
    if (lst) begin
      st = model_fail;
      if (st == ST_OK && model_phase != PH_DIGITS && model_phase != PH_ENDED) begin
        st = ST_SYNTAX;
      end
      produced   = 1'b1;
      res.status = st;
      if (st == ST_OK) begin
        res.value = model_neg ? (64'd0 - model_acc) : model_acc;
      end
      model_acc   = '0;
      model_neg   = 1'b0;
      model_phase = PH_START;
      model_fail  = ST_OK;
    end
  endtask

  // Idle length: mostly none or short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one byte and hold it until the request is taken
  task automatic drive_byte(input logic [7:0] c, input logic lst);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_byte <= c;
    last_byte <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send a whole string, queueing the typed or the modeled result
  task automatic send_text(input text_q_t txt, input bit typed, input conv_result_t typed_res);
    bit           produced;
    bit           lst;
    conv_result_t res;
    for (int i = 0; i < txt.size(); i++) begin
      lst = (i == txt.size() - 1);
      drive_byte(txt[i], lst);
      if (lst || (model_fail == ST_OK && model_phase != PH_ENDED)) begin
        live_bytes++;
      end
      fold_text_byte(txt[i], lst, produced, res);
      if (produced) begin
        pending_conversions.push_back(typed ? typed_res : res);
      end
    end
  endtask

  // Hold the sender until every result is back and the pipe is empty
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] wm, input logic sm);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH_MODE;
    cfg_data  <= wm;
    @(posedge clk);
    model_width = wm;
    cfg_index <= CFG_SIGNED_MODE;
    cfg_data  <= {1'($urandom_range(0, 1)), sm};
    @(posedge clk);
    model_signed = sm;
    cfg_we <= 1'b0;
  endtask

  // Number text, well-formed but for a minus in unsigned mode, often near the limit, sometimes with tail junk
  task automatic build_number(output text_q_t txt);
    int unsigned r;
    logic        ng;
    logic [63:0] lim;
    logic [64:0] mag;
    logic [7:0]  junk;
    string       s;
    txt = {};
    r  = $urandom_range(0, 9);
    ng = (r >= 8);
    if (r >= 8) begin
      txt.push_back(CHAR_MINUS);
    end else if (r >= 6) begin
      txt.push_back(CHAR_PLUS);
    end
    lim = range_limit(model_width, model_signed, ng && model_signed);
    r   = $urandom_range(0, 9);
    if (r < 3) begin
      mag = {1'b0, lim} + 65'($urandom_range(0, 6)) - 65'd3;
    end else if (r < 6) begin
      mag = 65'($urandom_range(0, 999));
    end else begin
      mag = {1'b0, $urandom, $urandom} >> $urandom_range(0, 63);
    end
    s = $sformatf("%0d", mag);
    if ($urandom_range(0, 9) == 0) begin
      s = {"00", s};
    end
    for (int i = 0; i < s.len(); i++) begin
      txt.push_back(s[i]);
    end
    if ($urandom_range(0, 6) == 0) begin
      do junk = 8'($urandom_range(0, 255)); while (junk >= CHAR_ZERO && junk <= CHAR_NINE);
      txt.push_back(junk);
      repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Broken or random text: lone signs, double signs, arbitrary bytes
  task automatic build_noise(output text_q_t txt);
    int unsigned r;
    int unsigned n;
    txt = {};
    n   = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 8) begin
        txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end else if (r < 10) begin
        txt.push_back(CHAR_MINUS);
      end else if (r < 12) begin
        txt.push_back(CHAR_PLUS);
      end else begin
        txt.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver: random stalls, with long stretches both ways
  initial begin
    int unsigned r;
    int unsigned n;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 8);
      end else if (r < 18) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 4);
      end else if (r == 18) begin
        out_ready <= 1'b0;
        n = $urandom_range(20, 60);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(50, 200);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_results
    conv_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_conversions.size() == 0) begin
        $error("unexpected result: value_bits %h status %0d", value_bits, status);
        mismatch_count++;
      end else begin
        want = pending_conversions.pop_front();
        if (value_bits !== want.value) begin
          $error("value_bits: expected %h, actual %h", want.value, value_bits);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    text_case_t   directed_cases[$];
    text_case_t   tc;
    text_q_t      txt;
    conv_result_t typed_res;
    int unsigned  setting;
    int unsigned  strings_left;
    int unsigned  phase_idx;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_WIDTH_MODE;
    cfg_data  = WM_64;
    in_valid  = 1'b0;
    char_byte = 8'h00;
    last_byte = 1'b0;
    mismatch_count = 0;
    live_bytes     = 0;
    calm           = 1'b0;
    model_width    = WM_64;
    model_signed   = 1'b1;
    model_acc      = '0;
    model_neg      = 1'b0;
    model_phase    = PH_START;
    model_fail     = ST_OK;

    // Directed strings; a typed row carries its own expected result
    directed_cases.push_back('{WM_64, 1'b1, "0",     1'b1, 64'd0, ST_OK});
    directed_cases.push_back('{WM_64, 1'b1, "+",     1'b1, 64'd0, ST_SYNTAX});
    directed_cases.push_back('{WM_64, 1'b1, "-",     1'b1, 64'd0, ST_SYNTAX});
    directed_cases.push_back('{WM_64, 1'b1, "x",     1'b1, 64'd0, ST_SYNTAX});
    directed_cases.push_back('{WM_64, 1'b1, "--1",   1'b1, 64'd0, ST_SYNTAX});
    directed_cases.push_back('{WM_64, 1'b1, "12x9",  1'b0, 64'd0, ST_OK});
    directed_cases.push_back('{WM_64, 1'b1, "+7",    1'b0, 64'd0, ST_OK});
    directed_cases.push_back('{WM_8,  1'b0, "255",   1'b1, 64'd255, ST_OK});
    directed_cases.push_back('{WM_8,  1'b0, "2569",  1'b1, 64'd0, ST_RANGE});
    directed_cases.push_back('{WM_8,  1'b0, "-1",    1'b1, 64'd0, ST_SYNTAX});
    directed_cases.push_back('{WM_8,  1'b1, "127",   1'b1, 64'd127, ST_OK});
    directed_cases.push_back('{WM_8,  1'b1, "128",   1'b1, 64'd0, ST_RANGE});
    directed_cases.push_back('{WM_8,  1'b1, "-128",  1'b1, 64'hFFFF_FFFF_FFFF_FF80, ST_OK});
    directed_cases.push_back('{WM_8,  1'b1, "-129",  1'b1, 64'd0, ST_RANGE});
    directed_cases.push_back('{WM_16, 1'b1, "9a-",   1'b0, 64'd0, ST_OK});
    directed_cases.push_back('{WM_16, 1'b0, "65536", 1'b1, 64'd0, ST_RANGE});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_cases[k]) begin
      tc = directed_cases[k];
      if (tc.width_mode != model_width || tc.signed_mode != model_signed) begin
        write_config(tc.width_mode, tc.signed_mode);
      end
      txt = {};
      for (int i = 0; i < tc.text.len(); i++) begin
        txt.push_back(tc.text[i]);
      end
      typed_res.value  = tc.value;
      typed_res.status = tc.status;
      send_text(txt, tc.typed, typed_res);
    end

    // Random phases: all eight settings first, then random ones
    live_bytes = 0;
    phase_idx  = 0;
    typed_res.value  = '0;
    typed_res.status = ST_OK;
    while (live_bytes < 1300) begin
      setting = (phase_idx < 8) ? phase_idx : $urandom_range(0, 7);
      write_config(setting[1:0], setting[2]);
      calm = ($urandom_range(0, 4) == 0);
      strings_left = $urandom_range(10, 25);
      while (strings_left > 0 && live_bytes < 1300) begin
        if ($urandom_range(0, 9) < 7) begin
          build_number(txt);
        end else begin
          build_noise(txt);
        end
        send_text(txt, 1'b0, typed_res);
        strings_left--;
      end
      phase_idx++;
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/dtti_pkg.sv
rtl/core/dtti_step.sv
rtl/core/decimal_text_to_integer.sv
tb/sv/testbench.sv
